@@ hw/rtl/bldc_pkg.sv @@
`timescale 1ns / 1ps

package bldc_pkg;

    // Event codes carried in the action field
    typedef enum logic [2:0] {
        ACT_SINGLE  = 3'd0,
        ACT_DOUBLE  = 3'd1,
        ACT_LONG    = 3'd2,
        ACT_HOLD    = 3'd3,
        ACT_RELEASE = 3'd4,
        ACT_LINK    = 3'd5
    } act_t;

    // Link-status codes carried with a link event
    typedef enum logic [1:0] {
        LINK_CONNECTING = 2'd0,
        LINK_CONNECTED  = 2'd1,
        LINK_FAILED     = 2'd2,
        LINK_NONE       = 2'd3
    } link_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_STEP_DIV  = 2'd0,
        REG_STEP_PCT  = 2'd1,
        REG_MIN_PCT   = 2'd2,
        REG_MAX_PCT   = 2'd3
    } reg_idx_t;

    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

    localparam logic [7:0] RST_STEP_DIV = 8'd12;
    localparam logic [5:0] RST_STEP_PCT = 6'd2;
    localparam logic [6:0] RST_MIN_PCT  = 7'd5;
    localparam logic [6:0] RST_MAX_PCT  = 7'd100;
    localparam logic [6:0] RST_LEVEL    = 7'd100;

    localparam logic [23:0] RGB_WARM  = {8'd255, 8'd160, 8'd80};
    localparam logic [23:0] RGB_AMBER = {8'd255, 8'd160, 8'd0};
    localparam logic [23:0] RGB_GREEN = {8'd0, 8'd255, 8'd0};
    localparam logic [23:0] RGB_RED   = {8'd255, 8'd0, 8'd0};

    typedef struct packed {
        logic [7:0] step_div;
        logic [5:0] step_pct;
        logic [6:0] min_pct;
        logic [6:0] max_pct;
    } cfg_t;

    typedef struct packed {
        logic       dimming;
        logic       breathing;
        logic [6:0] brightness;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       lamp_on;
    } res_t;

    // Palette colour {r, g, b}; the upper eight entries repeat the lower eight
    function automatic logic [23:0] pal_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        unique case (idx[2:0])
            3'd0: rgb = RGB_WARM;
            3'd1: rgb = {8'd255, 8'd0, 8'd0};
            3'd2: rgb = {8'd0, 8'd255, 8'd0};
            3'd3: rgb = {8'd0, 8'd0, 8'd255};
            3'd4: rgb = {8'd255, 8'd200, 8'd0};
            3'd5: rgb = {8'd200, 8'd0, 8'd255};
            3'd6: rgb = {8'd0, 8'd255, 8'd255};
            3'd7: rgb = {8'd255, 8'd255, 8'd255};
        endcase
        return rgb;
    endfunction

endpackage

@@ hw/rtl/button_lamp_dimmer_control.sv @@
`timescale 1ns / 1ps

// Lamp controller driven by button gestures and link-status events. Each beat on
// the slave side is one event and yields exactly one result beat on the master
// side carrying the lamp state after that event (on flag, colour, brightness,
// breathing and dimming flags). An event is held in the input register, where
// the state update is computed, and then lands in the output register; one
// event is taken every cycle as long as the master side keeps tready high. The
// four configuration registers are written through cfg_we / cfg_index /
// cfg_wdata; the user must write them only while no event is in flight, as the
// block itself does not enforce this.

module button_lamp_dimmer_control #(
    parameter int PALETTE_SIZE = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [bldc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Event stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [2:0] action, [4:3] link_status, [7:5] zero
    input  logic [bldc_pkg::IN_DATA_W-1:0]    s_tdata,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] lamp_on, [8:1] red, [16:9] green, [24:17] blue, [31:25] brightness,
    // [32] breathing, [33] dimming, [39:34] zero
    output logic [bldc_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import bldc_pkg::*;

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [2:0] action_reg;
    logic [1:0] link_reg;
    logic       advance;
    res_t       res;

    // Hold configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_div <= RST_STEP_DIV;
            cfg_reg.step_pct <= RST_STEP_PCT;
            cfg_reg.min_pct  <= RST_MIN_PCT;
            cfg_reg.max_pct  <= RST_MAX_PCT;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_STEP_DIV: cfg_reg.step_div <= cfg_wdata;
                REG_STEP_PCT: cfg_reg.step_pct <= cfg_wdata[5:0];
                REG_MIN_PCT:  cfg_reg.min_pct  <= cfg_wdata[6:0];
                REG_MAX_PCT:  cfg_reg.max_pct  <= cfg_wdata[6:0];
            endcase
        end
    end

    // Move the held event on whenever the output register is free or draining
    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            action_reg <= s_tdata[2:0];
            link_reg   <= s_tdata[4:3];
        end
    end

    bldc_core #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .action      (action_reg),
        .link_status (link_reg),
        .cfg         (cfg_reg),
        .res         (res)
    );

    bldc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

@@ hw/rtl/bldc_core.sv @@
`timescale 1ns / 1ps

module bldc_core #(
    parameter int PALETTE_SIZE = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [2:0]        action,
    input  logic [1:0]        link_status,
    input  bldc_pkg::cfg_t    cfg,
    output bldc_pkg::res_t    res
);
    import bldc_pkg::*;

    localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PALETTE_SIZE - 1);

    logic             lamp_reg,   lamp_next;
    logic [IDX_W-1:0] pidx_reg,   pidx_next;
    logic [23:0]      rgb_reg,    rgb_next;
    logic [6:0]       level_reg,  level_next;
    logic             up_reg,     up_next;
    logic             dim_reg,    dim_next;
    logic [7:0]       tick_reg,   tick_next;
    logic             breath_reg, breath_next;

    logic [IDX_W-1:0] pidx_inc;
    logic [7:0]       tick_inc;
    logic [7:0]       up_sum;
    logic [7:0]       dn_lim;

    assign pidx_inc = (pidx_reg == IDX_LAST) ? '0 : pidx_reg + 1'b1;
    assign tick_inc = tick_reg + 8'd1;
    assign up_sum   = {1'b0, level_reg} + {2'b00, cfg.step_pct};
    assign dn_lim   = {1'b0, cfg.min_pct} + {2'b00, cfg.step_pct};

    // Next state for the event at the head of the input register
    always_comb begin
        lamp_next   = lamp_reg;
        pidx_next   = pidx_reg;
        rgb_next    = rgb_reg;
        level_next  = level_reg;
        up_next     = up_reg;
        dim_next    = dim_reg;
        tick_next   = tick_reg;
        breath_next = breath_reg;
        unique case (act_t'(action))
            ACT_SINGLE: begin
                lamp_next = !lamp_reg;
            end
            ACT_DOUBLE: begin
                lamp_next = 1'b1;
                pidx_next = pidx_inc;
                rgb_next  = pal_rgb(4'(pidx_inc));
            end
            ACT_LONG: begin
                dim_next  = 1'b1;
                tick_next = '0;
                if (!lamp_reg) begin
                    level_next = cfg.min_pct;
                    up_next    = 1'b1;
                    lamp_next  = 1'b1;
                end else if (level_reg >= cfg.max_pct) begin
                    up_next = 1'b0;
                end else if (level_reg <= cfg.min_pct) begin
                    up_next = 1'b1;
                end
            end
            ACT_HOLD: begin
                if (dim_reg) begin
                    if (tick_inc < cfg.step_div) begin
                        tick_next = tick_inc;
                    end else begin
                        tick_next = '0;
                        // Step toward the bound in the current direction, saturating
                        if (up_reg) begin
                            if (level_reg < cfg.max_pct) begin
                                if (up_sum >= {1'b0, cfg.max_pct}) begin
                                    level_next = cfg.max_pct;
                                end else begin
                                    level_next = up_sum[6:0];
                                end
                            end
                        end else begin
                            if (level_reg > cfg.min_pct) begin
                                if ({1'b0, level_reg} <= dn_lim) begin
                                    level_next = cfg.min_pct;
                                end else begin
                                    level_next = level_reg - {1'b0, cfg.step_pct};
                                end
                            end
                        end
                    end
                end
            end
            ACT_RELEASE: begin
                if (dim_reg) begin
                    dim_next = 1'b0;
                    up_next  = !up_reg;
                end
            end
            ACT_LINK: begin
                unique case (link_t'(link_status))
                    LINK_CONNECTING: begin
                        lamp_next   = 1'b1;
                        breath_next = 1'b1;
                        rgb_next    = RGB_AMBER;
                    end
                    LINK_CONNECTED: begin
                        lamp_next   = 1'b1;
                        breath_next = 1'b0;
                        rgb_next    = RGB_GREEN;
                    end
                    LINK_FAILED: begin
                        lamp_next   = 1'b1;
                        breath_next = 1'b0;
                        rgb_next    = RGB_RED;
                    end
                    LINK_NONE: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Commit the new state as the beat moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lamp_reg   <= 1'b0;
            pidx_reg   <= '0;
            rgb_reg    <= RGB_WARM;
            level_reg  <= RST_LEVEL;
            up_reg     <= 1'b0;
            dim_reg    <= 1'b0;
            tick_reg   <= '0;
            breath_reg <= 1'b0;
        end else if (advance) begin
            lamp_reg   <= lamp_next;
            pidx_reg   <= pidx_next;
            rgb_reg    <= rgb_next;
            level_reg  <= level_next;
            up_reg     <= up_next;
            dim_reg    <= dim_next;
            tick_reg   <= tick_next;
            breath_reg <= breath_next;
        end
    end

    assign res.lamp_on    = lamp_next;
    assign res.red        = rgb_next[23:16];
    assign res.green      = rgb_next[15:8];
    assign res.blue       = rgb_next[7:0];
    assign res.brightness = level_next;
    assign res.breathing  = breath_next;
    assign res.dimming    = dim_next;

endmodule

@@ hw/rtl/bldc_out_stage.sv @@
`timescale 1ns / 1ps

module bldc_out_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  bldc_pkg::res_t res,
    input  logic           m_tready,
    output logic           m_tvalid,
    output logic [bldc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import bldc_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    // Fill on advance, drain when the sink takes the beat
    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, res_reg};

endmodule
